FILE: rtl/ilid_pkg.sv
`default_nettype none

package ilid_pkg;

  localparam int POS_W      = 10;
  localparam int DATA_W     = 32;
  localparam int FILL_W     = 11;
  localparam int TREE_FANIN = 8;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    logic [FILL_W-1:0]        fill_count;
  } out_t;

  // Broadcast to every cell; at most one bit is set in a cycle.
  typedef struct packed {
    logic app;
    logic ins;
    logic del;
  } cell_cmd_t;

  // Number of registered levels in the read-out tree for n leaves.
  function automatic int tree_levels(int n);
    int lv;
    int span;
    lv   = 1;
    span = TREE_FANIN;
    while (span < n) begin
      lv   = lv + 1;
      span = span * TREE_FANIN;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ilid_cell.sv
`default_nettype none

module ilid_cell #(
  parameter int IDX = 0,
  parameter int PW  = 10,
  parameter int CW  = 11
) (
  input  wire logic                                 clk,
  input  wire ilid_pkg::cell_cmd_t                  cmd_i,
  input  wire logic [PW-1:0]                        pos_i,
  input  wire logic [CW-1:0]                        cnt_i,
  input  wire logic [PW-1:0]                        rd_pos_i,
  input  wire logic signed [ilid_pkg::DATA_W-1:0]   val_i,
  input  wire logic signed [ilid_pkg::DATA_W-1:0]   left_i,
  input  wire logic signed [ilid_pkg::DATA_W-1:0]   right_i,
  output logic signed [ilid_pkg::DATA_W-1:0]        data_o,
  output logic [ilid_pkg::DATA_W-1:0]               rd_o
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic signed [ilid_pkg::DATA_W-1:0] data_r;
  logic signed [ilid_pkg::DATA_W-1:0] data_nxt;

  // An insert takes from the left neighbour, a delete from the right one.
  always_comb begin
    priority if (cmd_i.app && (cnt_i == MY_CNT)) begin
      data_nxt = val_i;
    end else if (cmd_i.ins && (pos_i == MY_POS)) begin
      data_nxt = val_i;
    end else if (cmd_i.ins && (pos_i < MY_POS)) begin
      data_nxt = left_i;
    end else if (cmd_i.del && (pos_i <= MY_POS)) begin
      data_nxt = right_i;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (rd_pos_i == MY_POS) ? data_r : '0;

endmodule

`default_nettype wire

FILE: rtl/ilid_rd_tree.sv
`default_nettype none

module ilid_rd_tree #(
  parameter int N = 1024
) (
  input  wire logic                          clk,
  input  wire logic [ilid_pkg::DATA_W-1:0]   leaf_i [N],
  output logic [ilid_pkg::DATA_W-1:0]        root_o
);

  localparam int FAN    = ilid_pkg::TREE_FANIN;
  localparam int L      = ilid_pkg::tree_levels(N);
  localparam int LEAVES = FAN ** L;
  localparam int F      = (LEAVES - 1) / (FAN - 1);

  logic [ilid_pkg::DATA_W-1:0] pad [LEAVES];
  logic [ilid_pkg::DATA_W-1:0] node_r [F];

  for (genvar j = 0; j < LEAVES; j++) begin : g_pad
    if (j < N) begin : g_used
      assign pad[j] = leaf_i[j];
    end else begin : g_zero
      assign pad[j] = '0;
    end
  end

  // Heap order: node n has children FAN*n+1 .. FAN*n+FAN; indexes past the
  // internal nodes are leaves. Only one leaf is non-zero, so OR selects it.
  for (genvar n = 0; n < F; n++) begin : g_node
    logic [ilid_pkg::DATA_W-1:0] kid [FAN];
    logic [ilid_pkg::DATA_W-1:0] or_v;

    for (genvar m = 0; m < FAN; m++) begin : g_kid
      localparam int C = FAN * n + 1 + m;
      if (C >= F) begin : g_leaf
        assign kid[m] = pad[C-F];
      end else begin : g_inner
        assign kid[m] = node_r[C];
      end
    end

    always_comb begin
      or_v = '0;
      for (int k = 0; k < FAN; k++) begin
        or_v = or_v | kid[k];
      end
    end

    always_ff @(posedge clk) begin
      node_r[n] <= or_v;
    end
  end

  assign root_o = node_r[0];

endmodule

`default_nettype wire

FILE: rtl/indexed_list_insert_delete.sv
// Channel   Ports                      Handshake
// input     start, busy, in_data       beat taken when start is high and busy is low
// result    out_valid, out_data        one-cycle strobe, always taken
//
// Clear, append, insert and delete finish at the accepting edge: every cell
// shifts or loads in parallel and the result is strobed in the next cycle.
// A valid read walks an 8-way registered OR tree over the cells, L levels
// deep (L = ceil(log8 DEPTH), 4 at the default); busy stays high while
// rd_cnt counts up to L, and the result follows in the cycle busy falls.
// Reset (rst_n low at a clock edge) empties the list; cell contents are kept.
// The receiver cannot stall, so nothing here waits on the result side.
`default_nettype none

module indexed_list_insert_delete #(
  parameter int DEPTH = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire ilid_pkg::in_t  in_data,
  output logic                out_valid,
  output ilid_pkg::out_t      out_data
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int PW  = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;
  localparam int L   = ilid_pkg::tree_levels(DEPTH);
  localparam int LCW = $clog2(L + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [ilid_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [LCW-1:0]                 rd_cnt_r, rd_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ilid_pkg::out_t                 out_r, out_nxt;
  ilid_pkg::status_t              status;
  ilid_pkg::cell_cmd_t            cmd;

  logic                           acc;
  logic                           idx_ok;
  logic                           full;
  logic [PW-1:0]                  pos_ext;
  logic [PW-1:0]                  rd_pos_ext;

  logic signed [ilid_pkg::DATA_W-1:0] cell_q  [DEPTH];
  logic [ilid_pkg::DATA_W-1:0]        cell_rd [DEPTH];
  logic [ilid_pkg::DATA_W-1:0]        root;

  assign busy       = (state_r == S_READ);
  assign acc        = start && !busy;
  assign pos_ext    = PW'(in_data.position);
  assign rd_pos_ext = PW'(pos_r);
  assign idx_ok     = pos_ext < PW'(count_r);
  assign full       = (count_r == CW'(DEPTH));

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ilid_pkg::DATA_W-1:0] left_v;
    logic signed [ilid_pkg::DATA_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_v = cell_q[g];
    end else begin : g_mid_r
      assign right_v = cell_q[g+1];
    end

    ilid_cell #(
      .IDX (g),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .cmd_i    (cmd),
      .pos_i    (pos_ext),
      .cnt_i    (count_r),
      .rd_pos_i (rd_pos_ext),
      .val_i    (in_data.value),
      .left_i   (left_v),
      .right_i  (right_v),
      .data_o   (cell_q[g]),
      .rd_o     (cell_rd[g])
    );
  end

  ilid_rd_tree #(
    .N (DEPTH)
  ) u_rd_tree (
    .clk    (clk),
    .leaf_i (cell_rd),
    .root_o (root)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    cmd           = '0;
    status        = ilid_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          unique case (in_data.opcode)
            ilid_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            ilid_pkg::OP_APPEND: begin
              if (full) begin
                status = ilid_pkg::ST_FULL;
              end else begin
                cmd.app   = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            ilid_pkg::OP_INSERT: begin
              if (!idx_ok) begin
                status = ilid_pkg::ST_BADIDX;
              end else if (full) begin
                status = ilid_pkg::ST_FULL;
              end else begin
                cmd.ins   = 1'b1;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            ilid_pkg::OP_DELETE: begin
              if (!idx_ok) begin
                status = ilid_pkg::ST_BADIDX;
              end else begin
                cmd.del   = 1'b1;
                count_nxt = CW'(count_r - 1'b1);
              end
            end
            ilid_pkg::OP_READ: begin
              if (!idx_ok) begin
                status = ilid_pkg::ST_BADIDX;
              end else begin
                // The result comes out of the registered tree; S_READ waits for it.
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
                pos_nxt       = in_data.position;
                rd_cnt_nxt    = '0;
              end
            end
            default: begin
            end
          endcase
          out_nxt.status     = status;
          out_nxt.read_value = '0;
          out_nxt.fill_count = ilid_pkg::FILL_W'(count_nxt);
        end
      end
      S_READ: begin
        rd_cnt_nxt = LCW'(rd_cnt_r + 1'b1);
        if (rd_cnt_r == LCW'(L)) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_nxt.status     = ilid_pkg::ST_OK;
          out_nxt.read_value = $signed(root);
          out_nxt.fill_count = ilid_pkg::FILL_W'(count_r);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_quiet_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobed while a read is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_next_cycle_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (state_nxt == S_IDLE)) |=> out_valid)
    else $error("non-read command gave no result in the next cycle");

  a_read_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("read ended without a result");

endmodule

`default_nettype wire

FILE: tb/indexed_list_insert_delete_test.sv
module indexed_list_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 1024;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;

  // Opcodes outside the enum, which the block must ignore.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  ilid_pkg::in_t  in_data = '0;
  logic busy;
  logic out_valid;
  ilid_pkg::out_t out_data;

  indexed_list_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the list as the block should hold it.
  logic signed [ilid_pkg::DATA_W-1:0] shadow_list [DEPTH];
  int   shadow_count = 0;
  ilid_pkg::out_t pending_results[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;

  function automatic ilid_pkg::in_t make_cmd(input logic [2:0] op, input int pos,
                                             input logic [ilid_pkg::DATA_W-1:0] val);
    ilid_pkg::in_t c;
    c.opcode   = op;
    c.position = pos[ilid_pkg::POS_W-1:0];
    c.value    = val;
    return c;
  endfunction

  function automatic ilid_pkg::out_t apply_to_list(input ilid_pkg::in_t c);
    ilid_pkg::out_t r;
    r.status     = ilid_pkg::ST_OK;
    r.read_value = '0;
    case (c.opcode)
      ilid_pkg::OP_CLEAR: shadow_count = 0;
      ilid_pkg::OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = ilid_pkg::ST_FULL;
        end else begin
          shadow_list[shadow_count] = c.value;
          shadow_count++;
        end
      end
      ilid_pkg::OP_INSERT: begin
        // The index is checked before the capacity.
        if (int'(c.position) >= shadow_count) begin
          r.status = ilid_pkg::ST_BADIDX;
        end else if (shadow_count >= DEPTH) begin
          r.status = ilid_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > int'(c.position); i--)
            shadow_list[i] = shadow_list[i-1];
          shadow_list[c.position] = c.value;
          shadow_count++;
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (int'(c.position) >= shadow_count) begin
          r.status = ilid_pkg::ST_BADIDX;
        end else begin
          for (int i = int'(c.position); i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      ilid_pkg::OP_READ: begin
        if (int'(c.position) >= shadow_count)
          r.status = ilid_pkg::ST_BADIDX;
        else
          r.read_value = shadow_list[c.position];
      end
      default: ;
    endcase
    r.fill_count = shadow_count[ilid_pkg::FILL_W-1:0];
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] %s", $realtime, msg);
  endtask

  // Offers one beat, idling at random first, and books its expected result
  // at the edge that takes it.
  task automatic send_cmd(input ilid_pkg::in_t c);
    logic [63:0] noise;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      noise = {$urandom, $urandom};
      start   <= 1'b0;
      in_data <= noise[$bits(ilid_pkg::in_t)-1:0];
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_to_list(c));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_cmd(make_cmd(ilid_pkg::OP_CLEAR,  0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 0, 32'h0BAD_0BAD));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 1023, 32'h7FFF_FFFF));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, 32'h8000_0000));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, 32'h0000_0000));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 0, 32'h1234_5678));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 2, 32'hA5A5_A5A5));
    // Insert at the fill count is refused: insert never appends.
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 6, 32'h5A5A_5A5A));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   5, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   6, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   1023, '0));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 5, '0));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   0, '0));
    for (logic [3:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++)
      send_cmd(make_cmd(op[2:0], 1023, 32'hFFFF_FFFF));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 1023, '0));
    send_cmd(make_cmd(ilid_pkg::OP_CLEAR,  0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, $urandom));
    wait_results_drained();
  endtask

  task automatic test_full_store();
    idle_pct = 0;
    send_cmd(make_cmd(ilid_pkg::OP_CLEAR, 0, '0));
    repeat (DEPTH)
      send_cmd(make_cmd(ilid_pkg::OP_APPEND, $urandom_range(0, 1023), $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 0, $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 1023, $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   1023, '0));
    send_cmd(make_cmd(ilid_pkg::OP_READ,   0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 1023, '0));
    send_cmd(make_cmd(ilid_pkg::OP_INSERT, 1022, $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, $urandom));
    send_cmd(make_cmd(ilid_pkg::OP_DELETE, 0, '0));
    send_cmd(make_cmd(ilid_pkg::OP_APPEND, 0, $urandom));
    repeat (16) send_cmd(make_cmd(ilid_pkg::OP_READ, $urandom_range(0, 1023), '0));
    send_cmd(make_cmd(ilid_pkg::OP_CLEAR, 0, '0));
    wait_results_drained();
  endtask

  // Mostly commands aimed at live entries, so the list keeps changing shape;
  // the occasional clear keeps it short.
  task automatic test_random_traffic(input int n_items, input int sender_idle);
    int   pick;
    int   pos;
    ilid_pkg::in_t c;
    idle_pct = sender_idle;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      pos  = (shadow_count == 0) ? 0 : $urandom_range(0, shadow_count - 1);
      if (pick < 20) begin
        c = make_cmd(ilid_pkg::OP_APPEND, $urandom_range(0, 1023), $urandom);
      end else if (pick < 40) begin
        c = make_cmd(ilid_pkg::OP_INSERT, pos, $urandom);
      end else if (pick < 65) begin
        c = make_cmd(ilid_pkg::OP_DELETE, pos, $urandom);
      end else if (pick < 90) begin
        c = make_cmd(ilid_pkg::OP_READ, pos, $urandom);
      end else if (pick < 95) begin
        pos = $urandom_range(shadow_count < 1023 ? shadow_count : 1023, 1023);
        case ($urandom_range(0, 2))
          0:       c = make_cmd(ilid_pkg::OP_INSERT, pos, $urandom);
          1:       c = make_cmd(ilid_pkg::OP_DELETE, pos, $urandom);
          default: c = make_cmd(ilid_pkg::OP_READ, pos, $urandom);
        endcase
      end else if (pick < 98) begin
        c = make_cmd(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                     $urandom_range(0, 1023), $urandom);
      end else begin
        c = make_cmd(ilid_pkg::OP_CLEAR, $urandom_range(0, 1023), $urandom);
      end
      send_cmd(c);
    end
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    ilid_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing outstanding: status %0d value %0d fill %0d",
                               out_data.status, out_data.read_value, out_data.fill_count));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.read_value !== want.read_value ||
            out_data.fill_count !== want.fill_count)
          note_failure($sformatf("status %0d/%0d value %0d/%0d fill %0d/%0d (expected/actual)",
                                 want.status, out_data.status,
                                 want.read_value, out_data.read_value,
                                 want.fill_count, out_data.fill_count));
      end
    end
    if ((start && !busy) || out_valid)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_store();
    test_random_traffic(200, 36);
    test_random_traffic(200, 47);
    test_random_traffic(100, 0);
    // A read keeps the block busy while it walks the tree; let any stray beat show.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
